FILE: rtl/rdx_pkg.sv
package rdx_pkg;

	localparam int VALUE_WIDTH = 31;
	localparam int BASE_W      = 6;
	localparam int CHAR_W      = 7;
	localparam int IDX_W       = $clog2(VALUE_WIDTH);

	localparam logic [BASE_W-1:0] MIN_BASE  = BASE_W'(2);
	localparam logic [BASE_W-1:0] MAX_BASE  = BASE_W'(36);
	localparam logic [BASE_W-1:0] DEC_LIMIT = BASE_W'(9);
	localparam logic [BASE_W-1:0] DEC_COUNT = BASE_W'(10);
	localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(8'h30);
	localparam logic [CHAR_W-1:0] ASCII_A    = CHAR_W'(8'h41);

	typedef logic [VALUE_WIDTH-1:0] value_t;
	typedef logic [BASE_W-1:0]      base_t;
	typedef logic [CHAR_W-1:0]      char_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	function automatic char_t to_ascii(input base_t d);
		char_t c;
		if (d > DEC_LIMIT) begin
			c = ASCII_A + CHAR_W'(d - DEC_COUNT);
		end else begin
			c = ASCII_ZERO + CHAR_W'(d);
		end
		return c;
	endfunction

endpackage

FILE: rtl/rdx_in_if.sv
interface rdx_in_if;
	logic            valid;
	logic            ready;
	rdx_pkg::value_t value;
	rdx_pkg::base_t  base;

	modport source (output valid, output value, output base, input ready);
	modport sink   (input valid, input value, input base, output ready);
endinterface

FILE: rtl/rdx_out_if.sv
interface rdx_out_if;
	logic           valid;
	logic           ready;
	rdx_pkg::char_t digit_char;
	logic           last;

	modport source (output valid, output digit_char, output last, input ready);
	modport sink   (input valid, input digit_char, input last, output ready);
endinterface

FILE: rtl/rdx_div.sv
// restoring divider, one quotient bit per cycle
module rdx_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  rdx_pkg::value_t     dividend,
	input  rdx_pkg::base_t      divisor,
	output rdx_pkg::value_t     quotient,
	output rdx_pkg::base_t      remainder,
	output rdx_pkg::div_stat_t  stat
);

	localparam int CNT_W = $clog2(rdx_pkg::VALUE_WIDTH);

	logic                       busy_q;
	logic                       done_q;
	logic [CNT_W-1:0]           cnt_q;
	rdx_pkg::value_t            acc_q;
	rdx_pkg::base_t             rem_q;
	logic [rdx_pkg::BASE_W:0]   trial;
	logic                       ge;
	rdx_pkg::base_t             rem_nxt;

	assign trial   = {rem_q, acc_q[rdx_pkg::VALUE_WIDTH-1]};
	assign ge      = trial >= {1'b0, divisor};
	assign rem_nxt = ge ? rdx_pkg::BASE_W'(trial - {1'b0, divisor})
	                    : trial[rdx_pkg::BASE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && (cnt_q == '0)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= dividend;
			rem_q <= '0;
			cnt_q <= CNT_W'(rdx_pkg::VALUE_WIDTH - 1);
		end else if (busy_q) begin
			acc_q <= {acc_q[rdx_pkg::VALUE_WIDTH-2:0], ge};
			rem_q <= rem_nxt;
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign quotient  = acc_q;
	assign remainder = rem_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

FILE: rtl/integer_to_radix_digits.sv
// channel | dir | fields            | notes
// item    | in  | value, base       | one number per beat
// digit   | out | digit_char, last  | one beat per digit, MS first
//
// Each digit costs one full division in the bit-serial divider; an item
// takes one division per digit, then one output beat per digit.
// item.ready is high only between items; digits are replayed from a small
// register file once the quotient reaches zero. Reset clears the sequencer
// and the output valid. A stalled digit beat holds until taken.
module integer_to_radix_digits (
	input  logic      clk,
	input  logic      arst_n,
	rdx_in_if.sink    item,
	rdx_out_if.source digit
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]                  state_q;
	logic                        start_q;
	logic                        valid_q;
	rdx_pkg::value_t             val_q;
	rdx_pkg::base_t              base_q;
	logic [rdx_pkg::IDX_W-1:0]   cnt_q;
	logic [rdx_pkg::IDX_W-1:0]   idx_q;
	rdx_pkg::char_t              char_q;
	logic                        last_q;
	rdx_pkg::base_t              dig_q [rdx_pkg::VALUE_WIDTH];

	rdx_pkg::base_t              base_sat;
	rdx_pkg::value_t             quot;
	rdx_pkg::base_t              rem;
	rdx_pkg::div_stat_t          div_stat;
	logic                        fin;

	always_comb begin
		if (item.base < rdx_pkg::MIN_BASE) begin
			base_sat = rdx_pkg::MIN_BASE;
		end else if (item.base > rdx_pkg::MAX_BASE) begin
			base_sat = rdx_pkg::MAX_BASE;
		end else begin
			base_sat = item.base;
		end
	end

	rdx_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start_q),
		.dividend  (val_q),
		.divisor   (base_q),
		.quotient  (quot),
		.remainder (rem),
		.stat      (div_stat)
	);

	assign fin = (state_q == ST_DIV) && div_stat.done && (quot == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			start_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (item.valid) begin
						start_q <= 1'b1;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						if (quot == '0) begin
							valid_q <= 1'b1;
							state_q <= ST_EMIT;
						end else begin
							start_q <= 1'b1;
						end
					end
				end
				ST_EMIT: begin
					if (digit.ready && last_q) begin
						valid_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					valid_q <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && item.valid) begin
			val_q  <= item.value;
			base_q <= base_sat;
			cnt_q  <= '0;
		end else if ((state_q == ST_DIV) && div_stat.done) begin
			dig_q[cnt_q] <= rem;
			val_q        <= quot;
			cnt_q        <= cnt_q + 1'b1;
		end
		if (fin) begin
			char_q <= rdx_pkg::to_ascii(rem);
			last_q <= (cnt_q == '0);
			idx_q  <= cnt_q - 1'b1;
		end else if ((state_q == ST_EMIT) && digit.ready && !last_q) begin
			char_q <= rdx_pkg::to_ascii(dig_q[idx_q]);
			last_q <= (idx_q == '0);
			idx_q  <= idx_q - 1'b1;
		end
	end

	assign item.ready       = (state_q == ST_IDLE);
	assign digit.valid      = valid_q;
	assign digit.digit_char = char_q;
	assign digit.last       = last_q;

`ifndef SYNTHESIS
	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		item.ready |-> !digit.valid)
		else $error("input ready while a digit is pending");

	a_more_digits: assert property (@(posedge clk) disable iff (!arst_n)
		digit.valid && digit.ready && !digit.last |=> digit.valid)
		else $error("digit stream ended without last");

	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> state_q == ST_DIV)
		else $error("divider busy outside division");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |=> div_stat.busy)
		else $error("divider did not start");
`endif

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps

module tb;
	import rdx_pkg::*;

	localparam int unsigned RADIX_LO  = 2;
	localparam int unsigned RADIX_HI  = 36;
	localparam char_t       CH_ZERO   = 7'h30;
	localparam char_t       CH_A      = 7'h41;
	localparam int          HOLD_LEN  = 500;
	localparam int          TAIL_WAIT = 120;
	localparam longint      MAX_CYCLES = 3_000_000;

	typedef struct {
		value_t value;
		base_t  base;
	} number_t;

	typedef struct {
		char_t ch;
		logic  last;
	} digit_beat_t;

	logic clk;
	logic arst_n;

	rdx_in_if  num_if ();
	rdx_out_if dig_if ();

	integer_to_radix_digits dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (num_if),
		.digit  (dig_if)
	);

	number_t     numbers_to_send[$];
	digit_beat_t digits_due[$];
	digit_beat_t want;
	int          errors;
	int          send_idle_pct;
	int          recv_stall_pct;
	logic        recv_hold;
	longint      cycles;

	// digits of one number, most significant first; base saturates to 2..36
	function automatic void predict_digits(input value_t v, input base_t b);
		int unsigned radix;
		int unsigned d;
		value_t      rest;
		digit_beat_t beats[$];
		digit_beat_t nb;
		radix = (b < RADIX_LO) ? RADIX_LO : ((b > RADIX_HI) ? RADIX_HI : int'(b));
		rest = v;
		do begin
			d = rest % radix;
			nb.ch = (d > 9) ? char_t'(CH_A + d - 10) : char_t'(CH_ZERO + d);
			nb.last = (beats.size() == 0);
			beats.push_front(nb);
			rest = rest / radix;
		end while (rest != 0);
		foreach (beats[i])
			digits_due.push_back(beats[i]);
	endfunction

	function automatic void queue_number(input value_t v, input base_t b);
		number_t n;
		n.value = v;
		n.base = b;
		numbers_to_send.push_back(n);
	endfunction

	function automatic value_t random_value();
		int unsigned w;
		w = $urandom_range(31, 1);
		return value_t'($urandom) & value_t'((64'd1 << w) - 1);
	endfunction

	function automatic base_t random_base();
		if ($urandom_range(99) < 88)
			return base_t'($urandom_range(RADIX_HI, RADIX_LO));
		return base_t'($urandom_range(63, 0));
	endfunction

	task automatic wait_drained();
		do @(negedge clk);
		while (numbers_to_send.size() != 0 || num_if.valid || digits_due.size() != 0);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		num_if.valid = 1'b0;
		num_if.value = '0;
		num_if.base = '0;
		dig_if.ready = 1'b0;
	end

	// number driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_if.valid <= 1'b0;
			num_if.value <= '0;
			num_if.base <= '0;
		end else begin
			if (num_if.valid && num_if.ready)
				predict_digits(num_if.value, num_if.base);
			if (!num_if.valid || num_if.ready) begin
				if (numbers_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					num_if.valid <= 1'b1;
					num_if.value <= numbers_to_send[0].value;
					num_if.base <= numbers_to_send[0].base;
					numbers_to_send.pop_front();
				end else begin
					num_if.valid <= 1'b0;
				end
			end
		end
	end

	// digit monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dig_if.ready <= 1'b0;
		end else begin
			if (dig_if.valid && dig_if.ready) begin
				if (digits_due.size() == 0) begin
					$display("%0t: unexpected digit beat: char %h last %b", $time,
						dig_if.digit_char, dig_if.last);
					errors++;
				end else begin
					want = digits_due.pop_front();
					if (dig_if.digit_char !== want.ch) begin
						$display("%0t: digit_char mismatch: expected %h, got %h", $time,
							want.ch, dig_if.digit_char);
						errors++;
					end
					if (dig_if.last !== want.last) begin
						$display("%0t: last mismatch: expected %b, got %b", $time,
							want.last, dig_if.last);
						errors++;
					end
				end
			end
			dig_if.ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= MAX_CYCLES) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		errors = 0;
		cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		recv_hold = 1'b0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed
		queue_number(value_t'(0), base_t'(10));
		queue_number(value_t'(0), base_t'(0));
		queue_number(value_t'(0), base_t'(63));
		queue_number('1, base_t'(2));
		queue_number('1, base_t'(36));
		queue_number('1, base_t'(10));
		queue_number('1, base_t'(0));
		queue_number('1, base_t'(1));
		queue_number('1, base_t'(37));
		queue_number('1, base_t'(63));
		queue_number(value_t'(1), base_t'(2));
		queue_number(value_t'(1000), base_t'(10));
		queue_number(value_t'(9), base_t'(10));
		queue_number(value_t'(10), base_t'(16));
		queue_number(value_t'(35), base_t'(36));
		queue_number(value_t'(1295), base_t'(36));
		queue_number(value_t'(1296), base_t'(36));
		queue_number(value_t'(342), base_t'(7));
		queue_number(value_t'(32'h4000_0000), base_t'(2));
		queue_number(value_t'(32'h5555_5555), base_t'(2));
		queue_number(value_t'(32'h2AAA_AAAA), base_t'(4));
		queue_number(value_t'(60466176), base_t'(6));
		queue_number(value_t'(2), base_t'(3));
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
				default: begin send_idle_pct = 33; recv_stall_pct = 33; end
			endcase
			for (int i = 0; i < 95; i++)
				queue_number(random_value(), random_base());
			if (ph == 0) begin
				// receiver blocked while the sender keeps offering numbers
				recv_hold = 1'b1;
				repeat (HOLD_LEN) @(negedge clk);
				recv_hold = 1'b0;
			end
			wait_drained();
		end

		repeat (TAIL_WAIT) @(negedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: files.f
rtl/rdx_pkg.sv
rtl/rdx_in_if.sv
rtl/rdx_out_if.sv
rtl/rdx_div.sv
rtl/integer_to_radix_digits.sv
verif/tb.sv
